FILE: sv/vector3_geometry_unit_core_macros.svh
// Assertion macros for the checker file of the vector geometry unit.
`ifndef VECTOR3_GEOMETRY_UNIT_CORE_MACROS_SVH
`define VECTOR3_GEOMETRY_UNIT_CORE_MACROS_SVH

// Checked on every rising edge outside of reset.
`define VGU_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("vector geometry unit check failed");

// Checked on every rising edge, reset included.
`define VGU_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("vector geometry unit check failed");

`endif

FILE: sv/vgu_pkg.sv
// Types, constants and step functions of the vector geometry unit.
`default_nettype none
package vgu_pkg;

   localparam logic [2:0] OP_ADD   = 3'd0;
   localparam logic [2:0] OP_DOT   = 3'd1;
   localparam logic [2:0] OP_CROSS = 3'd2;
   localparam logic [2:0] OP_LEN   = 3'd3;
   localparam logic [2:0] OP_UNIT  = 3'd4;
   localparam logic [2:0] OP_ANGLE = 3'd5;

   localparam int SQRT_STAGES = 25;
   localparam int DIV_STAGES  = 17;

   localparam logic [16:0]        ONE_Q16 = 17'd65536;
   localparam logic signed [32:0] PI_Q16  = 33'sd205887;
   localparam logic signed [19:0] AC_P0   = 20'sd102939;
   localparam logic signed [19:0] AC_P1   = -20'sd13901;
   localparam logic signed [19:0] AC_P2   = 20'sd4867;
   localparam logic signed [19:0] AC_P3   = -20'sd1227;

   typedef struct packed {
      logic [31:0]        aa;
      logic [31:0]        bb;
      logic signed [31:0] ab;
      logic signed [31:0] c1;
      logic signed [31:0] c2;
      logic signed [16:0] sum;
   } lane_out_type;

   typedef struct packed {
      logic [2:0]         opcode;
      logic [2:0][15:0]   a_vec;
      logic signed [32:0] dot;
      logic [2:0][32:0]   rvec;
      logic               a_zero;
      logic               b_zero;
   } meta_type;

   typedef struct packed {
      logic [26:0] rem;
      logic [24:0] root;
      logic [49:0] rest;
   } sqrt_state_type;

   typedef struct packed {
      logic [63:0] rem;
      logic [63:0] dsh;
      logic [16:0] q;
   } div_state_type;

   // One digit of the restoring square root: two radicand bits per step.
   function automatic sqrt_state_type sqrt_step(input sqrt_state_type s);
      sqrt_state_type o;
      logic [28:0] t_rem;
      logic [28:0] t_try;
      logic        ge;
      t_rem  = {s.rem, s.rest[49:48]};
      t_try  = {2'b00, s.root, 2'b01};
      ge     = (t_rem >= t_try);
      o.rem  = ge ? 27'(t_rem - t_try) : t_rem[26:0];
      o.root = {s.root[23:0], ge};
      o.rest = {s.rest[47:0], 2'b00};
      return o;
   endfunction

   // One quotient bit of the restoring divider.
   function automatic div_state_type div_step(input div_state_type s);
      div_state_type o;
      logic ge;
      ge    = (s.rem >= s.dsh);
      o.rem = ge ? (s.rem - s.dsh) : s.rem;
      o.dsh = {1'b0, s.dsh[63:1]};
      o.q   = {s.q[15:0], ge};
      return o;
   endfunction

   // Divide by 65536 with truncation toward zero.
   function automatic logic signed [37:0] trunc_q16(input logic signed [37:0] v);
      logic signed [37:0] bias;
      bias = v[37] ? 38'sd65535 : 38'sd0;
      return (v + bias) >>> 16;
   endfunction

endpackage
`default_nettype wire

FILE: sv/vgu_lane.sv
// One component lane: the products and the sum that one vector element needs.
`default_nettype none
module vgu_lane (
   input  logic                  clock,
   input  logic                  en,
   input  logic signed [15:0]    a_i,
   input  logic signed [15:0]    b_i,
   input  logic signed [15:0]    a_j,
   input  logic signed [15:0]    b_j,
   input  logic signed [15:0]    a_k,
   input  logic signed [15:0]    b_k,
   output vgu_pkg::lane_out_type lane_ff
);
   import vgu_pkg::*;

   lane_out_type lane_in;
   logic signed [31:0] aa_s;
   logic signed [31:0] bb_s;

   always_comb begin
      aa_s        = a_i * a_i;
      bb_s        = b_i * b_i;
      lane_in.aa  = aa_s;
      lane_in.bb  = bb_s;
      lane_in.ab  = a_i * b_i;
      lane_in.c1  = a_j * b_k;
      lane_in.c2  = b_j * a_k;
      lane_in.sum = 17'(a_i) + 17'(b_i);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lane_ff <= lane_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/vgu_merge.sv
// Merging stage: sums of squares, dot product and the vector result of add or cross.
`default_nettype none
module vgu_merge (
   input  logic                        clock,
   input  logic                        en,
   input  vgu_pkg::lane_out_type [2:0] lanes,
   input  logic [2:0]                  opcode,
   input  logic [2:0][15:0]            a_vec,
   output vgu_pkg::meta_type           meta_ff,
   output logic [31:0]                 sum_a_ff,
   output logic [31:0]                 sum_b_ff
);
   import vgu_pkg::*;

   meta_type    meta_in;
   logic [31:0] sum_a_in;
   logic [31:0] sum_b_in;

   always_comb begin
      sum_a_in = lanes[0].aa + lanes[1].aa + lanes[2].aa;
      sum_b_in = lanes[0].bb + lanes[1].bb + lanes[2].bb;
      meta_in.opcode = opcode;
      meta_in.a_vec  = a_vec;
      meta_in.dot    = 33'(lanes[0].ab) + 33'(lanes[1].ab) + 33'(lanes[2].ab);
      meta_in.a_zero = (sum_a_in == 32'd0);
      meta_in.b_zero = (sum_b_in == 32'd0);
      for (int i = 0; i < 3; i++) begin
         case (opcode)
            OP_ADD:   meta_in.rvec[i] = {{8{lanes[i].sum[16]}}, lanes[i].sum, 8'h00};
            OP_CROSS: meta_in.rvec[i] = 33'(lanes[i].c1) - 33'(lanes[i].c2);
            default:  meta_in.rvec[i] = 33'd0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         meta_ff  <= meta_in;
         sum_a_ff <= sum_a_in;
         sum_b_ff <= sum_b_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/vgu_sqrt.sv
// Pipelined integer square root, one root bit per stage.
`default_nettype none
module vgu_sqrt (
   input  logic        clock,
   input  logic        en,
   input  logic [49:0] radicand,
   output logic [24:0] root
);
   import vgu_pkg::*;

   sqrt_state_type stage_ff [SQRT_STAGES];
   sqrt_state_type first;

   always_comb begin
      first.rem  = 27'd0;
      first.root = 25'd0;
      first.rest = radicand;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff[0] <= sqrt_step(first);
         for (int k = 1; k < SQRT_STAGES; k++) begin
            stage_ff[k] <= sqrt_step(stage_ff[k-1]);
         end
      end
   end

   assign root = stage_ff[SQRT_STAGES-1].root;

endmodule
`default_nettype wire

FILE: sv/vgu_div.sv
// Pipelined restoring divider for quotients below 2^17, one bit per stage.
`default_nettype none
module vgu_div (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] numer,
   input  logic [47:0] denom,
   output logic [16:0] quot
);
   import vgu_pkg::*;

   div_state_type stage_ff [DIV_STAGES];
   div_state_type first;

   always_comb begin
      first.rem = numer;
      first.dsh = {denom, 16'h0000};
      first.q   = 17'd0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff[0] <= div_step(first);
         for (int k = 1; k < DIV_STAGES; k++) begin
            stage_ff[k] <= div_step(stage_ff[k-1]);
         end
      end
   end

   assign quot = stage_ff[DIV_STAGES-1].q;

endmodule
`default_nettype wire

FILE: sv/vector3_geometry_unit_core.sv
// Vector geometry unit: add, dot, cross, length, unit vector and angle of 3D vectors.
//
// Input transactions carry the opcode in req_tuser and the two Q8.8 vectors in
// req_tdata. Each accepted transaction yields exactly one result transaction on
// the rsp_ channel, with Q16.16 results in rsp_tdata and the perpendicular and
// zero-length flags in rsp_tuser. Results leave in the order the inputs came.
// Every opcode travels the same pipeline, whose depth is set by the chain of
// two 25-stage square roots, a 17-stage divider and the acos polynomial that
// the angle operation needs.
// Throughput is one transaction per cycle while the receiver does not stall.
// When the receiver holds rsp_tready low with a result waiting, the whole
// pipeline freezes and req_tready drops in the same cycle; nothing is lost.
// Synchronous reset empties the pipeline and clears rsp_tvalid; no memory needs
// clearing.
`default_nettype none
module vector3_geometry_unit_core (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // a_x, a_y, a_z, b_x, b_y, b_z from bit 0 up, 16 bits each
   input  logic [95:0]   req_tdata,
   // opcode
   input  logic [2:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // res_x, res_y, res_z, scalar_out from bit 0 up, 33 bits each, 4 zero bits
   output logic [135:0]  rsp_tdata,
   // perpendicular, zero_length from bit 0 up
   output logic [1:0]    rsp_tuser
);
   import vgu_pkg::*;

   localparam int T_LAST = 72;

   logic                     adv;
   logic [T_LAST:1]          valid_ff;
   logic [2:0]               op1_ff;
   logic [2:0][15:0]         a1_ff;
   logic signed [15:0]       a_in [3];
   logic signed [15:0]       b_in [3];
   lane_out_type [2:0]       lanes;
   meta_type                 meta2;
   logic [31:0]              sum_a;
   logic [31:0]              sum_b;
   meta_type                 meta_ff [3:T_LAST];
   logic [24:0]              la;
   logic [24:0]              lb;
   logic [24:0]              lad_ff [28:T_LAST];
   logic [2:0][15:0]         amag;
   logic [16:0]              uq [3];
   logic [2:0][16:0]         uq_ff [45:T_LAST];
   logic [63:0]              num28_ff;
   logic [47:0]              den28_ff;
   logic signed [32:0]       dot27;
   logic signed [32:0]       dabs;
   logic [16:0]              cq;
   logic [16:0]              cc_ff [46:50];
   logic [16:0]              cc_in;
   logic [16:0]              one_minus;
   logic [24:0]              s_root;
   logic signed [37:0]       m1_ff;
   logic signed [37:0]       m2_ff;
   logic signed [37:0]       m3_ff;
   logic signed [37:0]       m4_ff;
   logic signed [37:0]       t1;
   logic signed [37:0]       t2;
   logic signed [37:0]       t3;
   logic signed [19:0]       p1_ff;
   logic signed [19:0]       p2_ff;
   logic signed [19:0]       pd_ff [52:71];
   logic signed [37:0]       ang_full;
   logic signed [32:0]       ang;
   logic signed [17:0]       uq_s;
   meta_type                 mo;
   logic [2:0][32:0]         r_in;
   logic signed [32:0]       sc_in;
   logic                     perp_in;
   logic                     zl_in;
   logic                     rsp_tvalid_ff;
   logic [135:0]             rsp_tdata_ff;
   logic [1:0]               rsp_tuser_ff;

   assign adv        = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = adv;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         a_in[i] = req_tdata[16*i +: 16];
         b_in[i] = req_tdata[48 + 16*i +: 16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[T_LAST-1:1], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         op1_ff <= req_tuser;
         a1_ff  <= req_tdata[47:0];
      end
   end

   for (genvar g = 0; g < 3; g++) begin : g_lane
      vgu_lane u_lane (
         .clock   (clock),
         .en      (adv),
         .a_i     (a_in[g]),
         .b_i     (b_in[g]),
         .a_j     (a_in[(g+1)%3]),
         .b_j     (b_in[(g+1)%3]),
         .a_k     (a_in[(g+2)%3]),
         .b_k     (b_in[(g+2)%3]),
         .lane_ff (lanes[g])
      );
   end

   vgu_merge u_merge (
      .clock    (clock),
      .en       (adv),
      .lanes    (lanes),
      .opcode   (op1_ff),
      .a_vec    (a1_ff),
      .meta_ff  (meta2),
      .sum_a_ff (sum_a),
      .sum_b_ff (sum_b)
   );

   vgu_sqrt u_sqrt_a (
      .clock    (clock),
      .en       (adv),
      .radicand ({2'b00, sum_a, 16'h0000}),
      .root     (la)
   );

   vgu_sqrt u_sqrt_b (
      .clock    (clock),
      .en       (adv),
      .radicand ({2'b00, sum_b, 16'h0000}),
      .root     (lb)
   );

   // Unit vector lanes start as soon as the length of a is out.
   always_comb begin
      logic signed [16:0] wide;
      logic signed [16:0] mag;
      for (int i = 0; i < 3; i++) begin
         wide    = 17'($signed(meta_ff[27].a_vec[i]));
         mag     = wide[16] ? -wide : wide;
         amag[i] = mag[15:0];
      end
   end

   for (genvar g = 0; g < 3; g++) begin : g_unit
      vgu_div u_div (
         .clock (clock),
         .en    (adv),
         .numer ({24'h0, amag[g], 24'h0}),
         .denom ({24'h0, la[23:0]}),
         .quot  (uq[g])
      );
   end

   assign dot27 = meta_ff[27].dot;
   assign dabs  = dot27[32] ? -dot27 : dot27;

   always_ff @(posedge clock) begin
      if (adv) begin
         num28_ff <= {dabs[31:0], 32'h0};
         den28_ff <= la[23:0] * lb[23:0];
      end
   end

   vgu_div u_div_cos (
      .clock (clock),
      .en    (adv),
      .numer (num28_ff),
      .denom (den28_ff),
      .quot  (cq)
   );

   assign cc_in     = (cq > ONE_Q16) ? ONE_Q16 : cq;
   assign one_minus = ONE_Q16 - cc_ff[46];

   vgu_sqrt u_sqrt_c (
      .clock    (clock),
      .en       (adv),
      .radicand ({17'h0, one_minus, 16'h0000}),
      .root     (s_root)
   );

   assign t1 = trunc_q16(m1_ff);
   assign t2 = trunc_q16(m2_ff);
   assign t3 = trunc_q16(m3_ff);

   // Horner evaluation of the acos polynomial, one multiply per product register.
   always_ff @(posedge clock) begin
      if (adv) begin
         m1_ff     <= AC_P3 * $signed({1'b0, cc_ff[46]});
         p1_ff     <= t1[19:0] + AC_P2;
         m2_ff     <= p1_ff * $signed({1'b0, cc_ff[48]});
         p2_ff     <= t2[19:0] + AC_P1;
         m3_ff     <= p2_ff * $signed({1'b0, cc_ff[50]});
         m4_ff     <= $signed({1'b0, s_root[16:0]}) * pd_ff[71];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         meta_ff[3] <= meta2;
         for (int k = 4; k <= T_LAST; k++) begin
            meta_ff[k] <= meta_ff[k-1];
         end
         lad_ff[28] <= la;
         for (int k = 29; k <= T_LAST; k++) begin
            lad_ff[k] <= lad_ff[k-1];
         end
         uq_ff[45] <= {uq[2], uq[1], uq[0]};
         for (int k = 46; k <= T_LAST; k++) begin
            uq_ff[k] <= uq_ff[k-1];
         end
         cc_ff[46] <= cc_in;
         for (int k = 47; k <= 50; k++) begin
            cc_ff[k] <= cc_ff[k-1];
         end
         pd_ff[52] <= t3[19:0] + AC_P0;
         for (int k = 53; k <= 71; k++) begin
            pd_ff[k] <= pd_ff[k-1];
         end
      end
   end

   assign ang_full = trunc_q16(m4_ff);
   assign ang      = 33'(ang_full[19:0]);
   assign mo       = meta_ff[T_LAST];

   always_comb begin
      r_in    = '0;
      sc_in   = '0;
      perp_in = 1'b0;
      zl_in   = 1'b0;
      uq_s    = '0;
      case (mo.opcode)
         OP_ADD, OP_CROSS: begin
            r_in = mo.rvec;
         end
         OP_DOT: begin
            sc_in   = mo.dot;
            perp_in = (mo.dot == 33'sd0);
         end
         OP_LEN: begin
            sc_in = 33'(lad_ff[T_LAST]);
         end
         OP_UNIT: begin
            if (mo.a_zero) begin
               zl_in = 1'b1;
            end else begin
               for (int i = 0; i < 3; i++) begin
                  uq_s    = $signed({1'b0, uq_ff[T_LAST][i]});
                  r_in[i] = mo.a_vec[i][15] ? 33'(-uq_s) : 33'(uq_s);
               end
            end
         end
         OP_ANGLE: begin
            if (mo.a_zero || mo.b_zero) begin
               zl_in = 1'b1;
            end else begin
               sc_in = mo.dot[32] ? (PI_Q16 - ang) : ang;
            end
         end
         default: begin
            r_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (adv) begin
         rsp_tvalid_ff <= valid_ff[T_LAST];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_tdata_ff <= {4'h0, sc_in, r_in[2], r_in[1], r_in[0]};
         rsp_tuser_ff <= {zl_in, perp_in};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule
`default_nettype wire

FILE: sv/vgu_checker.sv
// Port-level checks of the vector geometry unit, bound to the top level.
`default_nettype none
`include "vector3_geometry_unit_core_macros.svh"
module vgu_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [135:0] rsp_tdata,
   input logic [1:0]   rsp_tuser
);

   `VGU_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid)

   `VGU_ASSERT(a_hold_stalled, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // Input is only held off while a result waits on a stalled receiver.
   `VGU_ASSERT(a_ready_open, clock, reset, (!rsp_tvalid || rsp_tready) |-> req_tready)

   `VGU_ASSERT(a_flags_apart, clock, reset, rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))

   // A zero dot product or a zero-length failure always reports a zero scalar.
   `VGU_ASSERT(a_flag_scalar, clock, reset, rsp_tvalid && (rsp_tuser[0] || rsp_tuser[1]) |-> rsp_tdata[131:99] == 33'd0)

endmodule

bind vector3_geometry_unit_core vgu_checker u_vgu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

FILE: tb/vector3_geometry_unit_core_tb.sv
// Self-checking testbench for the vector geometry unit core.
`default_nettype none
module vector3_geometry_unit_core_tb;
   import vgu_pkg::*;

   typedef struct {
      logic [2:0]  op;
      logic [15:0] a [3];
      logic [15:0] b [3];
   } vec_req_type;

   typedef struct {
      logic [32:0] rx, ry, rz, sc;
      logic        perp, zlen;
   } vec_rsp_type;

   typedef struct {
      logic [2:0]  op;
      logic [15:0] ax, ay, az, bx, by, bz;
      logic        typed;
      logic [32:0] rx, ry, rz, sc;
      logic        perp, zlen;
   } stim_row_type;

   localparam int LATENCY    = 73;
   localparam int WATCH_MAX  = 5000;
   localparam int RAND_ITEMS = 450;
   localparam int N_ROWS     = 18;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [95:0]   req_tdata = '0;
   logic [2:0]    req_tuser = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [135:0]  rsp_tdata;
   logic [1:0]    rsp_tuser;

   vec_rsp_type result_queue [$];
   int  fail_count = 0;
   int  idle_cycles = 0;
   bit  stim_done = 0;
   bit  hold_active = 0;
   stim_row_type rows [N_ROWS];

   always #10 clock = ~clock;

   vector3_geometry_unit_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   function automatic longint unsigned int_sqrt(input longint unsigned n);
      longint unsigned r, t;
      r = 0;
      for (int i = 24; i >= 0; i--) begin
         t = r | (64'd1 << i);
         if (t * t <= n) r = t;
      end
      return r;
   endfunction

   function automatic longint unsigned magnitude(input longint v[3]);
      longint unsigned s;
      s = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
      return int_sqrt(s << 16);
   endfunction

   function automatic longint acos_approx(input longint c);
      longint p, s;
      p = AC_P3;
      p = (p * c) / 65536 + AC_P2;
      p = (p * c) / 65536 + AC_P1;
      p = (p * c) / 65536 + AC_P0;
      s = longint'(int_sqrt(longint'(65536 - c) << 16));
      return (s * p) / 65536;
   endfunction

   function automatic vec_rsp_type compute_geometry(input vec_req_type q);
      vec_rsp_type o;
      longint a[3], b[3], r[3], sc, d, mag;
      longint unsigned la, lb, c;
      r = '{0, 0, 0};
      sc = 0;
      o.perp = 0;
      o.zlen = 0;
      for (int i = 0; i < 3; i++) begin
         a[i] = longint'($signed(q.a[i]));
         b[i] = longint'($signed(q.b[i]));
      end
      case (q.op)
         OP_ADD: for (int i = 0; i < 3; i++) r[i] = (a[i] + b[i]) * 256;
         OP_DOT: begin
            sc = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
            o.perp = (sc == 0);
         end
         OP_CROSS: begin
            r[0] = a[1] * b[2] - b[1] * a[2];
            r[1] = a[2] * b[0] - b[2] * a[0];
            r[2] = a[0] * b[1] - b[0] * a[1];
         end
         OP_LEN: sc = longint'(magnitude(a));
         OP_UNIT: begin
            la = magnitude(a);
            if (la == 0) o.zlen = 1;
            else for (int i = 0; i < 3; i++) r[i] = (a[i] * 16777216) / longint'(la);
         end
         OP_ANGLE: begin
            la = magnitude(a);
            lb = magnitude(b);
            if (la == 0 || lb == 0) o.zlen = 1;
            else begin
               d = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
               mag = (d < 0) ? -d : d;
               c = (longint'(mag) << 32) / (la * lb);
               if (c > 65536) c = 65536;
               sc = acos_approx(longint'(c));
               if (d < 0) sc = 205887 - sc;
            end
         end
         default: ;
      endcase
      o.rx = r[0][32:0];
      o.ry = r[1][32:0];
      o.rz = r[2][32:0];
      o.sc = sc[32:0];
      return o;
   endfunction

   function automatic stim_row_type row(input logic [2:0] op, input logic [15:0] ax, ay, az,
                                        bx, by, bz);
      stim_row_type s;
      s = '{op: op, ax: ax, ay: ay, az: az, bx: bx, by: by, bz: bz, typed: 0,
            rx: '0, ry: '0, rz: '0, sc: '0, perp: 0, zlen: 0};
      return s;
   endfunction

   // Called at a falling edge; valid stays high between transactions sent with no gap.
   task automatic send_item(input vec_req_type q, input vec_rsp_type expected);
      int gap;
      gap = $urandom_range(0, 3);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {q.b[2], q.b[1], q.b[0], q.a[2], q.a[1], q.a[0]};
      req_tuser  <= q.op;
      result_queue = {result_queue, expected};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_checked(input vec_req_type q);
      send_item(q, compute_geometry(q));
   endtask

   function automatic logic [15:0] rand_comp();
      case ($urandom_range(0, 5))
         0: return 16'h0000;
         1: return 16'h7fff;
         2: return 16'h8000;
         3: return 16'($signed($urandom_range(0, 1024)) - 512);
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      vec_req_type q;
      vec_rsp_type e;
      rows[0]  = row(OP_ADD,   16'h7fff, 16'h8000, 16'h0000, 16'h7fff, 16'h8000, 16'hffff);
      rows[0].typed = 1;
      rows[0].rx = 33'h0_00ff_fe00; rows[0].ry = 33'h1_ff00_0000; rows[0].rz = 33'h1_ffff_ff00;
      rows[1]  = row(OP_DOT,   16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0000);
      rows[1].typed = 1; rows[1].perp = 1;
      rows[2]  = row(OP_DOT,   16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      rows[3]  = row(OP_DOT,   16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
      rows[4]  = row(OP_CROSS, 16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0000);
      rows[4].typed = 1; rows[4].rz = 33'h0_0001_0000;
      rows[5]  = row(OP_CROSS, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
      rows[6]  = row(OP_LEN,   16'h0000, 16'h0000, 16'h0000, 16'h1234, 16'h0000, 16'h0000);
      rows[6].typed = 1;
      rows[7]  = row(OP_LEN,   16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'h0000);
      rows[8]  = row(OP_LEN,   16'h0300, 16'h0400, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      rows[8].typed = 1; rows[8].sc = 33'h0_0005_0000;
      rows[9]  = row(OP_UNIT,  16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0100, 16'h0100);
      rows[9].typed = 1; rows[9].zlen = 1;
      rows[10] = row(OP_UNIT,  16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      rows[10].typed = 1; rows[10].rx = 33'h1_ffff_0000;
      rows[11] = row(OP_UNIT,  16'h7fff, 16'h0001, 16'h8000, 16'h0000, 16'h0000, 16'h0000);
      rows[12] = row(OP_ANGLE, 16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'h0000);
      rows[12].typed = 1; rows[12].zlen = 1;
      rows[13] = row(OP_ANGLE, 16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      rows[13].typed = 1; rows[13].zlen = 1;
      rows[14] = row(OP_ANGLE, 16'h0100, 16'h0000, 16'h0000, 16'h0300, 16'h0000, 16'h0000);
      rows[15] = row(OP_ANGLE, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000);
      rows[16] = row(3'd6,     16'h1234, 16'h5678, 16'h9abc, 16'hdef0, 16'h0001, 16'hffff);
      rows[16].typed = 1;
      rows[17] = row(3'd7,     16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
      rows[17].typed = 1;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         q.op = rows[i].op;
         q.a = '{rows[i].ax, rows[i].ay, rows[i].az};
         q.b = '{rows[i].bx, rows[i].by, rows[i].bz};
         if (rows[i].typed) begin
            e = '{rx: rows[i].rx, ry: rows[i].ry, rz: rows[i].rz, sc: rows[i].sc,
                  perp: rows[i].perp, zlen: rows[i].zlen};
            send_item(q, e);
         end else begin
            send_checked(q);
         end
      end

      for (int n = 0; n < RAND_ITEMS; n++) begin
         q.op = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7))
                                             : 3'($urandom_range(0, 5));
         for (int k = 0; k < 3; k++) begin
            q.a[k] = rand_comp();
            q.b[k] = rand_comp();
         end
         // Perpendicular pairs exercise the flag and the right-angle path.
         if ($urandom_range(0, 9) == 0) begin
            q.b[0] = q.a[1];
            q.b[1] = -q.a[0];
            q.b[2] = 16'h0000;
         end
         if (n == 100) hold_active = 1;
         send_checked(q);
      end
      req_tvalid <= 1'b0;
      stim_done = 1;
   end

   // Receiver: random stalls, plus one long hold-off to fill the pipeline.
   initial begin
      int wait_n;
      @(negedge clock);
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_active) begin
            rsp_tready <= 1'b0;
            repeat (200) @(negedge clock);
            hold_active = 0;
         end
         wait_n = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 3);
         if (wait_n != 0) begin
            rsp_tready <= 1'b0;
            repeat (wait_n - 1) @(negedge clock);
            @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      vec_rsp_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (result_queue.size() == 0) begin
            $error("result with no expectation waiting");
            fail_count++;
         end else begin
            e = result_queue.pop_front();
            if (rsp_tdata[32:0] !== e.rx) begin
               $error("res_x expected %h got %h", e.rx, rsp_tdata[32:0]); fail_count++;
            end
            if (rsp_tdata[65:33] !== e.ry) begin
               $error("res_y expected %h got %h", e.ry, rsp_tdata[65:33]); fail_count++;
            end
            if (rsp_tdata[98:66] !== e.rz) begin
               $error("res_z expected %h got %h", e.rz, rsp_tdata[98:66]); fail_count++;
            end
            if (rsp_tdata[131:99] !== e.sc) begin
               $error("scalar_out expected %h got %h", e.sc, rsp_tdata[131:99]);
               fail_count++;
            end
            if (rsp_tuser[0] !== e.perp) begin
               $error("perpendicular expected %b got %b", e.perp, rsp_tuser[0]);
               fail_count++;
            end
            if (rsp_tuser[1] !== e.zlen) begin
               $error("zero_length expected %b got %b", e.zlen, rsp_tuser[1]);
               fail_count++;
            end
         end
      end
   end

   // Watchdog over cycles in which no transaction moves on either side.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_MAX) begin
         $display("** vector3_geometry_unit_core: FAILED **");
         $finish;
      end
   end

   initial begin
      wait (stim_done);
      wait (result_queue.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      if (fail_count == 0 && result_queue.size() == 0)
         $display("** vector3_geometry_unit_core: PASSED **");
      else
         $display("** vector3_geometry_unit_core: FAILED **");
      $finish;
   end

endmodule
`default_nettype wire

FILE: sim.f
+incdir+sv
sv/vgu_pkg.sv
sv/vgu_lane.sv
sv/vgu_merge.sv
sv/vgu_sqrt.sv
sv/vgu_div.sv
sv/vector3_geometry_unit_core.sv
sv/vgu_checker.sv
tb/vector3_geometry_unit_core_tb.sv
